FILE: rtl/primality_test_32bit_macros.svh
// Assertion macros for the primality tester.
// Included by the top level; no other dependencies.
`ifndef PRIMALITY_TEST_32BIT_MACROS_SVH
`define PRIMALITY_TEST_32BIT_MACROS_SVH

// Concurrent check that is disabled while reset is active.
`define PT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds at every clock edge, including during reset.
`define PT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ptest_pkg.sv
// Shared types and constants for the primality tester.
// No dependencies.
package ptest_pkg;

	localparam int unsigned W = 32;

	// Trial divisors 3..37.
	localparam int unsigned NTRIAL = 11;
	typedef logic [5:0] small_t;

	function automatic small_t trial_prime(input logic [3:0] i);
		small_t r;
		begin
			unique case (i)
				4'd0: r = 6'd3;
				4'd1: r = 6'd5;
				4'd2: r = 6'd7;
				4'd3: r = 6'd11;
				4'd4: r = 6'd13;
				4'd5: r = 6'd17;
				4'd6: r = 6'd19;
				4'd7: r = 6'd23;
				4'd8: r = 6'd29;
				4'd9: r = 6'd31;
				default: r = 6'd37;
			endcase
			return r;
		end
	endfunction

	// Miller-Rabin bases.
	localparam int unsigned NBASE = 5;

	function automatic small_t mr_base(input logic [2:0] i);
		small_t r;
		begin
			unique case (i)
				3'd0: r = 6'd2;
				3'd1: r = 6'd3;
				3'd2: r = 6'd5;
				3'd3: r = 6'd7;
				default: r = 6'd11;
			endcase
			return r;
		end
	endfunction

	// Request into the shared modular reduction unit.
	typedef struct packed {
		logic          start;
		logic [63:0]   num;
		logic [W-1:0]  modulus;
	} mod_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [W-1:0]  rem;
	} mod_rsp_t;

endpackage

FILE: rtl/ptest_modred.sv
// Shared reducer: 64-bit value mod 32-bit modulus, one quotient bit per cycle.
// Depends on ptest_pkg.
module ptest_modred (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptest_pkg::mod_req_t  req,
	output ptest_pkg::mod_rsp_t  rsp
);

	logic [ptest_pkg::W:0]   rem_q;
	logic [63:0]             num_q;
	logic [ptest_pkg::W-1:0] mod_q;
	logic [6:0]              cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [ptest_pkg::W+1:0] trial;
	logic [ptest_pkg::W:0]   shifted;

	// Restoring step: shift in the next numerator bit and subtract if it fits.
	always_comb begin
		shifted = {rem_q[ptest_pkg::W-1:0], num_q[63]};
		trial   = {1'b0, shifted} - {2'b00, mod_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				num_q  <= req.num;
				mod_q  <= req.modulus;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				if (!trial[ptest_pkg::W+1])
					rem_q <= trial[ptest_pkg::W:0];
				else
					rem_q <= shifted;
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[ptest_pkg::W-1:0];

endmodule

FILE: rtl/primality_test_32bit.sv
// Top level of the 32-bit deterministic primality tester.
// Depends on ptest_pkg, ptest_modred and primality_test_32bit_macros.svh.
//
// Usage:
//   Input channel: candidate with in_valid / in_stall. A transaction is
//   taken when in_valid is high and in_stall is low; in_stall stays high
//   from acceptance until the result has been handed to the output register.
//   Output channel: is_prime with out_valid / out_stall. The result is held
//   in an output register until the receiver takes it (out_stall low).
//   A new candidate may be accepted while a finished result still waits.
//   Cost: every reduction goes through the shared bit-serial reducer.
//   Trial division takes up to 11 reductions; each Miller-Rabin base takes
//   at most 62 (31 exponent bits, multiply and square). Trivial candidates
//   (below 2, even) skip the reducer and go straight to the final state.
//   The one reducer sets the rate: one candidate in flight at a time.
//   Reset: asynchronous, clears the sequencer and output valid; no
//   per-candidate state survives between transactions.
//   Stall: when out_stall holds a result and a second one finishes, the
//   sequencer waits in its final state until the output register frees.
`include "primality_test_32bit_macros.svh"
module primality_test_32bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIAL,
		ST_TRIAL_WAIT,
		ST_BASE,
		ST_POW_MUL,
		ST_POW_MUL_WAIT,
		ST_POW_SQR,
		ST_POW_SQR_WAIT,
		ST_CHECK,
		ST_SQ,
		ST_SQ_WAIT,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [31:0]             n_q;
	logic [31:0]             d_q;
	logic [5:0]              s_q;
	logic [31:0]             exp_q;
	logic [31:0]             acc_q;
	logic [31:0]             b_q;
	logic [5:0]              k_q;
	logic [3:0]              ti_q;
	logic [2:0]              bi_q;
	logic                    res_q;
	logic                    out_valid_q;
	logic                    out_q;

	ptest_pkg::mod_req_t     req;
	ptest_pkg::mod_rsp_t     rsp;
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             prod;
	logic [31:0]             nm1;
	logic                    out_free;

	ptest_modred u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign nm1      = n_q - 32'd1;
	assign out_free = !out_valid_q || !out_stall;

	// Operand select for the one multiplier feeding the reducer.
	assign mul_a = (state_q == ST_POW_SQR) ? b_q : acc_q;
	assign mul_b = (state_q == ST_SQ) ? acc_q : b_q;

	always_comb begin
		unique case (state_q)
			ST_POW_MUL, ST_POW_SQR, ST_SQ: prod = 64'(mul_a) * 64'(mul_b);
			ST_TRIAL:   prod = {32'd0, n_q};
			default:    prod = '0;
		endcase
	end

	// Reducer request; the multiply step only runs for a set exponent bit.
	always_comb begin
		req.num     = prod;
		req.modulus = (state_q == ST_TRIAL) ? {26'd0, ptest_pkg::trial_prime(ti_q)} : n_q;
		req.start   = (state_q == ST_TRIAL) || (state_q == ST_POW_MUL && exp_q[0]) ||
			(state_q == ST_POW_SQR) || (state_q == ST_SQ);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ti_q        <= '0;
			bi_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q <= candidate;
						d_q <= '0;
						ti_q <= '0;
						bi_q <= '0;
						if (candidate == 32'd2) begin
							res_q <= 1'b1;
							state_q <= ST_DONE;
						end else if (candidate < 32'd2 || !candidate[0]) begin
							res_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_TRIAL;
						end
					end
				end
				ST_TRIAL: state_q <= ST_TRIAL_WAIT;
				ST_TRIAL_WAIT: begin
					if (rsp.done) begin
						if (n_q == {26'd0, ptest_pkg::trial_prime(ti_q)}) begin
							res_q <= 1'b1;
							state_q <= ST_DONE;
						end else if (rsp.rem == 32'd0) begin
							res_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (ti_q == 4'(ptest_pkg::NTRIAL - 1)) begin
							state_q <= ST_BASE;
						end else begin
							ti_q <= ti_q + 4'd1;
							state_q <= ST_TRIAL;
						end
					end
				end
				ST_BASE: begin
					// n > 37 here so base < n; set up d, s, x.
					if (d_q == 32'd0) begin
						d_q <= nm1;
						s_q <= '0;
					end else if (!d_q[0]) begin
						d_q <= {1'b0, d_q[31:1]};
						s_q <= s_q + 6'd1;
					end else begin
						exp_q <= d_q;
						acc_q <= 32'd1;
						b_q <= {26'd0, ptest_pkg::mr_base(bi_q)};
						state_q <= ST_POW_MUL;
					end
				end
				ST_POW_MUL: begin
					if (exp_q == 32'd0)
						state_q <= ST_CHECK;
					else if (!exp_q[0])
						state_q <= ST_POW_SQR;
					else
						state_q <= ST_POW_MUL_WAIT;
				end
				ST_POW_MUL_WAIT: begin
					if (rsp.done) begin
						acc_q <= rsp.rem;
						state_q <= ST_POW_SQR;
					end
				end
				ST_POW_SQR: state_q <= ST_POW_SQR_WAIT;
				ST_POW_SQR_WAIT: begin
					if (rsp.done) begin
						b_q <= rsp.rem;
						exp_q <= {1'b0, exp_q[31:1]};
						state_q <= ST_POW_MUL;
					end
				end
				ST_CHECK: begin
					k_q <= 6'd1;
					if (acc_q == 32'd1 || acc_q == nm1) begin
						if (bi_q == 3'(ptest_pkg::NBASE - 1)) begin
							res_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							bi_q <= bi_q + 3'd1;
							d_q <= 32'd0;
							state_q <= ST_BASE;
						end
					end else if (s_q <= 6'd1) begin
						res_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_SQ_WAIT;
				ST_SQ_WAIT: begin
					if (rsp.done) begin
						acc_q <= rsp.rem;
						if (rsp.rem == nm1) begin
							if (bi_q == 3'(ptest_pkg::NBASE - 1)) begin
								res_q <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								bi_q <= bi_q + 3'd1;
								d_q <= 32'd0;
								state_q <= ST_BASE;
							end
						end else if (k_q + 6'd1 >= s_q) begin
							res_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							k_q <= k_q + 6'd1;
							state_q <= ST_SQ;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= res_q;
						d_q <= 32'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Handshake outputs.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = out_q;

	`PT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(is_prime), "result dropped while stalled")
	`PT_ASSERT(a_stall_busy, rsp.busy |-> in_stall, "input ready while reducer busy")
	`PT_ASSERT_ALWAYS(a_no_red_idle, !arst_n || state_q != ST_IDLE || !rsp.done, "reducer finished while idle")

endmodule
